>>> hdl/lzwa_pkg.sv
// Shared constants and types of the LZW compressor with ASCII85 output.
package lzwa_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam int CLEAR_CODE = 256;
    localparam int END_CODE   = 257;
    localparam int FIRST_FREE = 258;
    localparam int MIN_BITS   = 9;
    localparam int N_ROOTS    = 256;

    localparam int CODE_FW  = 16;
    localparam int WIDTH_FW = 5;

    localparam logic [31:0] A85_MAGIC = 32'hC0C0C0C1;
    localparam int          A85_SHIFT = 38;
    localparam logic [7:0]  A85_BASE  = 8'd33;
    localparam logic [7:0]  CH_Z      = 8'h7A;
    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_TILDE  = 8'h7E;
    localparam logic [7:0]  CH_GT     = 8'h3E;

    localparam logic       MODE_RESET   = 1'b1;
    localparam logic [7:0] LINE_W_RESET = 8'd75;
    localparam logic [7:0] LINE_W_MIN   = 8'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_LINE = 1'b1;

    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_FIN = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [1:0]          op;
        logic [CODE_FW-1:0]  code;
        logic [WIDTH_FW-1:0] width;
    } t_emit_cmd;

endpackage

>>> hdl/lzw_compressor_ascii85_out_core.sv
// Top level: LZW dictionary walk and code sequencing over the packer and output stage.
// Each later byte walks the tree from the prefix's own entry, S_LOOKUP then S_CHECK per entry read;
// adding an entry passes S_ADD_LINK, S_ADD_SLOT, S_PUT_PREFIX and S_GROW; the first byte of a stream
// goes through S_CLEAR; code and end steps wait on the packer. A new byte is taken only in S_IDLE.
// Output: a raw byte leaves per cycle unless stalled; an ASCII85 group is divided, then written out.
// Reset: synchronous, active low; config, bit buffer and root links clear at once, no clear pass.
module lzw_compressor_ascii85_out_core #(
    parameter int TABLE_ENTRIES = lzwa_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = lzwa_pkg::MAX_CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int NC_W = ((AW > MAX_CODE_BITS) ? AW : MAX_CODE_BITS) + 1;
    localparam int CW_W = $clog2(MAX_CODE_BITS + 1);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_LOOKUP     = 4'd1;
    localparam logic [3:0] S_CHECK      = 4'd2;
    localparam logic [3:0] S_ADD_LINK   = 4'd3;
    localparam logic [3:0] S_ADD_SLOT   = 4'd4;
    localparam logic [3:0] S_PUT_PREFIX = 4'd5;
    localparam logic [3:0] S_GROW       = 4'd6;
    localparam logic [3:0] S_CLEAR      = 4'd7;
    localparam logic [3:0] S_TAIL       = 4'd8;
    localparam logic [3:0] S_PUT_LAST   = 4'd9;
    localparam logic [3:0] S_PUT_END    = 4'd10;
    localparam logic [3:0] S_FINISH     = 4'd11;
    localparam logic [3:0] S_ENDITEM    = 4'd12;

    localparam logic [1:0] FLD_CHILD = 2'd0;
    localparam logic [1:0] FLD_LEFT  = 2'd1;
    localparam logic [1:0] FLD_RIGHT = 2'd2;

    logic [3:0]      r_state,  n_state;
    logic [7:0]      r_c,      n_c;
    logic            r_last,   n_last;
    logic            r_started, n_started;
    logic [AW-1:0]   r_prefix, n_prefix;
    logic [NC_W-1:0] r_next,   n_next;
    logic [CW_W-1:0] r_cw,     n_cw;
    logic [AW-1:0]   r_node,   n_node;
    logic            r_root,   n_root;
    logic [AW-1:0]   r_at,     n_at;
    logic [1:0]      r_field,  n_field;
    logic [AW-1:0]   r_wchild, n_wchild;
    logic [AW-1:0]   r_wleft,  n_wleft;
    logic [AW-1:0]   r_wright, n_wright;
    logic [7:0]      r_wchar,  n_wchar;
    logic            r_a85_mode;
    logic [7:0]      r_line_width;

    logic                rd_en;
    logic [AW-1:0]       rd_child, rd_left, rd_right;
    logic [7:0]          rd_char;
    logic                wr_en;
    logic [AW-1:0]       wr_addr, wr_child, wr_left, wr_right;
    logic [7:0]          wr_char;
    logic                clear_roots;
    lzwa_pkg::t_emit_cmd cmd;
    logic                emit_ready;
    logic                in_acc;
    logic [AW-1:0]       slot;
    logic [NC_W-1:0]     pow_cw;
    logic                tbl_full;

    lzwa_dict #(
        .DEPTH (TABLE_ENTRIES)
    ) u_dict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear_roots (clear_roots),
        .i_rd_en       (rd_en),
        .i_rd_addr     (r_node),
        .o_child       (rd_child),
        .o_left        (rd_left),
        .o_right       (rd_right),
        .o_char        (rd_char),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_child    (wr_child),
        .i_wr_left     (wr_left),
        .i_wr_right    (wr_right),
        .i_wr_char     (wr_char)
    );

    lzwa_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_ready       (emit_ready),
        .i_a85_mode    (r_a85_mode),
        .i_line_width  (r_line_width),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign slot       = r_next[AW-1:0];
    assign pow_cw     = NC_W'(1) << r_cw;
    assign tbl_full   = (r_next >= NC_W'(TABLE_ENTRIES)) ||
                        (r_next == pow_cw && r_cw >= CW_W'(MAX_CODE_BITS));

    always_comb begin
        n_state = r_state;  n_c = r_c;  n_last = r_last;  n_started = r_started;
        n_prefix = r_prefix;  n_next = r_next;  n_cw = r_cw;  n_node = r_node;
        n_root = r_root;  n_at = r_at;  n_field = r_field;
        n_wchild = r_wchild;  n_wleft = r_wleft;  n_wright = r_wright;  n_wchar = r_wchar;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_at;
        wr_child    = r_wchild;
        wr_left     = r_wleft;
        wr_right    = r_wright;
        wr_char     = r_wchar;
        clear_roots = 1'b0;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_c    = i_in_byte;
                    n_last = i_end_of_stream;
                    if (!r_started) begin
                        n_prefix  = AW'(i_in_byte);
                        n_cw      = CW_W'(lzwa_pkg::MIN_BITS);
                        n_started = 1'b1;
                        n_state   = S_CLEAR;
                    end else begin
                        n_node  = r_prefix;
                        n_root  = 1'b1;
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                rd_en   = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_wchild = rd_child;
                n_wleft  = rd_left;
                n_wright = rd_right;
                n_wchar  = rd_char;
                if (r_root) begin
                    if (rd_child == '0) begin
                        n_at    = r_node;
                        n_field = FLD_CHILD;
                        n_state = S_ADD_LINK;
                    end else begin
                        n_node  = rd_child;
                        n_root  = 1'b0;
                        n_state = S_LOOKUP;
                    end
                end else if (r_c == rd_char) begin
                    n_prefix = r_node;
                    n_state  = S_TAIL;
                end else if (r_c > rd_char) begin
                    if (rd_right == '0) begin
                        n_at    = r_node;
                        n_field = FLD_RIGHT;
                        n_state = S_ADD_LINK;
                    end else begin
                        n_node  = rd_right;
                        n_state = S_LOOKUP;
                    end
                end else begin
                    if (rd_left == '0) begin
                        n_at    = r_node;
                        n_field = FLD_LEFT;
                        n_state = S_ADD_LINK;
                    end else begin
                        n_node  = rd_left;
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_ADD_LINK: begin
                wr_en = 1'b1;
                case (r_field)
                    FLD_CHILD: wr_child = slot;
                    FLD_LEFT:  wr_left  = slot;
                    FLD_RIGHT: wr_right = slot;
                    default:   wr_child = r_wchild;
                endcase
                n_state = S_ADD_SLOT;
            end
            S_ADD_SLOT: begin
                wr_en    = 1'b1;
                wr_addr  = slot;
                wr_child = '0;
                wr_left  = '0;
                wr_right = '0;
                wr_char  = r_c;
                n_next   = r_next + NC_W'(1);
                n_state  = S_PUT_PREFIX;
            end
            S_PUT_PREFIX: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_PUT;
                cmd.code  = lzwa_pkg::CODE_FW'(r_prefix);
                cmd.width = lzwa_pkg::WIDTH_FW'(r_cw);
                if (emit_ready) begin
                    n_prefix = AW'(r_c);
                    n_state  = S_GROW;
                end
            end
            S_GROW: begin
                if (tbl_full) begin
                    n_state = S_CLEAR;
                end else begin
                    if (r_next == pow_cw) begin
                        n_cw = r_cw + CW_W'(1);
                    end
                    n_state = S_TAIL;
                end
            end
            S_CLEAR: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_PUT;
                cmd.code  = lzwa_pkg::CODE_FW'(lzwa_pkg::CLEAR_CODE);
                cmd.width = lzwa_pkg::WIDTH_FW'(r_cw);
                if (emit_ready) begin
                    clear_roots = 1'b1;
                    n_cw        = CW_W'(lzwa_pkg::MIN_BITS);
                    n_next      = NC_W'(lzwa_pkg::FIRST_FREE);
                    n_state     = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = r_last ? S_PUT_LAST : S_ENDITEM;
            end
            S_PUT_LAST: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_PUT;
                cmd.code  = lzwa_pkg::CODE_FW'(r_prefix);
                cmd.width = lzwa_pkg::WIDTH_FW'(r_cw);
                if (emit_ready) begin
                    n_state = S_PUT_END;
                end
            end
            S_PUT_END: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_PUT;
                cmd.code  = lzwa_pkg::CODE_FW'(lzwa_pkg::END_CODE);
                cmd.width = lzwa_pkg::WIDTH_FW'(r_cw);
                if (emit_ready) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_FIN;
                if (emit_ready) begin
                    n_started = 1'b0;
                    n_state   = S_ENDITEM;
                end
            end
            S_ENDITEM: begin
                cmd.valid = 1'b1;
                cmd.op    = lzwa_pkg::OP_END;
                if (emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_prefix  <= '0;
            r_next    <= NC_W'(lzwa_pkg::FIRST_FREE);
            r_cw      <= CW_W'(lzwa_pkg::MIN_BITS);
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_prefix  <= n_prefix;
            r_next    <= n_next;
            r_cw      <= n_cw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c      <= n_c;
        r_last   <= n_last;
        r_node   <= n_node;
        r_root   <= n_root;
        r_at     <= n_at;
        r_field  <= n_field;
        r_wchild <= n_wchild;
        r_wleft  <= n_wleft;
        r_wright <= n_wright;
        r_wchar  <= n_wchar;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a85_mode   <= lzwa_pkg::MODE_RESET;
            r_line_width <= lzwa_pkg::LINE_W_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lzwa_pkg::CFG_MODE: r_a85_mode   <= i_cfg_data[0];
                lzwa_pkg::CFG_LINE: r_line_width <= i_cfg_data;
                default:            r_a85_mode   <= r_a85_mode;
            endcase
        end
    end

endmodule

>>> hdl/lzwa_dict.sv
// Dictionary memory: child, left, right links and entry character per code.
module lzwa_dict #(
    parameter int DEPTH = lzwa_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear_roots,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [$clog2(DEPTH)-1:0] o_child,
    output logic [$clog2(DEPTH)-1:0] o_left,
    output logic [$clog2(DEPTH)-1:0] o_right,
    output logic [7:0]               o_char,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_child,
    input  logic [$clog2(DEPTH)-1:0] i_wr_left,
    input  logic [$clog2(DEPTH)-1:0] i_wr_right,
    input  logic [7:0]               i_wr_char
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = 3 * AW + 8;

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rd;
    logic          r_rd_ok;
    logic [lzwa_pkg::N_ROOTS-1:0] r_root_v;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_child, i_wr_left, i_wr_right, i_wr_char};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear_roots) begin
            r_root_v <= '0;
        end else if (i_wr_en && i_wr_addr < AW'(lzwa_pkg::N_ROOTS)) begin
            r_root_v[i_wr_addr[7:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_ok <= (i_rd_addr < AW'(lzwa_pkg::N_ROOTS)) ? r_root_v[i_rd_addr[7:0]] : 1'b1;
        end
    end

    assign o_child = r_rd_ok ? r_rd[DW-1:2*AW+8] : '0;
    assign o_left  = r_rd[2*AW+7:AW+8];
    assign o_right = r_rd[AW+7:8];
    assign o_char  = r_rd[7:0];

endmodule

>>> hdl/lzwa_b85.sv
// Base-85 digit unit: five digits of a 32-bit group by four divisions, each a multiply then a quotient phase.
module lzwa_b85 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_value,
    output logic            o_done,
    output logic [4:0][7:0] o_digits
);

    logic            r_busy;
    logic            r_phase;
    logic [1:0]      r_k;
    logic            r_done;
    logic [31:0]     r_v;
    logic [63:0]     r_prod;
    logic [4:0][7:0] r_dig;
    logic [25:0]     w_q;
    logic [31:0]     w_rem;

    assign w_q   = r_prod[63:lzwa_pkg::A85_SHIFT];
    assign w_rem = r_v - (32'(w_q) * 32'd85);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_k     <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_prod <= 64'(r_v) * 64'(lzwa_pkg::A85_MAGIC);
            end else begin
                r_v <= 32'(w_q);
                r_dig[3'd4 - 3'(r_k)] <= w_rem[7:0] + lzwa_pkg::A85_BASE;
                if (r_k == 2'd3) begin
                    r_dig[0] <= w_q[7:0] + lzwa_pkg::A85_BASE;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_dig;

endmodule

>>> hdl/lzwa_emit.sv
// Code packer and output stage: bit buffer, raw bytes or ASCII85, line breaks, beat register.
module lzwa_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzwa_pkg::t_emit_cmd i_cmd,
    output logic                o_ready,
    input  logic                i_a85_mode,
    input  logic [7:0]          i_line_width,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_char,
    output logic                o_last_of_run
);

    localparam logic [3:0] E_IDLE  = 4'd0;
    localparam logic [3:0] E_DRAIN = 4'd1;
    localparam logic [3:0] E_FLUSH = 4'd2;
    localparam logic [3:0] E_GRP   = 4'd3;
    localparam logic [3:0] E_DIV   = 4'd4;
    localparam logic [3:0] E_NEXT  = 4'd5;
    localparam logic [3:0] E_CH    = 4'd6;
    localparam logic [3:0] E_NL    = 4'd7;
    localparam logic [3:0] E_TILDE = 4'd8;
    localparam logic [3:0] E_GT    = 4'd9;
    localparam logic [3:0] E_LAST  = 4'd10;

    logic [3:0]  r_st,   n_st;
    logic [63:0] r_acc,  n_acc;
    logic [6:0]  r_abc,  n_abc;
    logic [7:0]  r_col,  n_col;
    logic [31:0] r_grp,  n_grp;
    logic [2:0]  r_rem,  n_rem;
    logic [2:0]  r_idx,  n_idx;
    logic        r_fin,  n_fin;
    logic [7:0]  r_ch,   n_ch;
    logic [7:0]  r_pend, n_pend;
    logic        r_pend_v, n_pend_v;
    logic        r_out_v,  n_out_v;
    logic [7:0]  r_out_ch, n_out_ch;
    logic        r_out_last, n_out_last;

    logic            push_req;
    logic [7:0]      push_ch;
    logic            push_ok;
    logic            out_free;
    logic            div_start;
    logic            div_done;
    logic [4:0][7:0] digits;
    logic [7:0]      lw_eff;
    logic [7:0]      col_inc;
    logic [lzwa_pkg::CODE_FW-1:0] code_m;
    logic [6:0]      put_sh;
    logic [2:0]      nbytes;

    lzwa_b85 u_b85 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_value  (r_grp),
        .o_done   (div_done),
        .o_digits (digits)
    );

    assign out_free = !r_out_v || !i_out_stall;
    assign push_ok  = push_req && (!r_pend_v || out_free);
    assign lw_eff   = (i_line_width < lzwa_pkg::LINE_W_MIN) ? lzwa_pkg::LINE_W_MIN
                                                            : i_line_width;
    assign col_inc  = r_col + 8'd1;
    assign code_m   = i_cmd.code &
                      lzwa_pkg::CODE_FW'((17'd1 << i_cmd.width) - 17'd1);
    assign put_sh   = 7'd64 - r_abc - 7'(i_cmd.width);
    assign nbytes   = 3'((r_abc + 7'd7) >> 3);

    always_comb begin
        n_st = r_st;  n_acc = r_acc;  n_abc = r_abc;  n_col = r_col;
        n_grp = r_grp;  n_rem = r_rem;  n_idx = r_idx;  n_fin = r_fin;
        n_ch = r_ch;
        push_req  = 1'b0;
        push_ch   = r_ch;
        div_start = 1'b0;
        case (r_st)
            E_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.op)
                        lzwa_pkg::OP_PUT: begin
                            n_acc = r_acc | (64'(code_m) << put_sh);
                            n_abc = r_abc + 7'(i_cmd.width);
                            n_st  = E_DRAIN;
                        end
                        lzwa_pkg::OP_FIN: begin
                            if (i_a85_mode) begin
                                if (r_abc != '0) begin
                                    n_grp = r_acc[63:32];
                                    n_rem = nbytes + 3'd1;
                                    n_fin = 1'b1;
                                    n_st  = E_GRP;
                                end else begin
                                    n_st = E_TILDE;
                                end
                            end else begin
                                n_st = E_FLUSH;
                            end
                        end
                        lzwa_pkg::OP_END: n_st = E_LAST;
                        default: n_st = E_IDLE;
                    endcase
                end
            end
            E_DRAIN: begin
                if (i_a85_mode) begin
                    if (r_abc >= 7'd32) begin
                        n_grp = r_acc[63:32];
                        n_acc = r_acc << 32;
                        n_abc = r_abc - 7'd32;
                        n_rem = 3'd5;
                        n_fin = 1'b0;
                        n_st  = E_GRP;
                    end else begin
                        n_st = E_IDLE;
                    end
                end else if (r_abc >= 7'd8) begin
                    push_req = 1'b1;
                    push_ch  = r_acc[63:56];
                    if (push_ok) begin
                        n_acc = r_acc << 8;
                        n_abc = r_abc - 7'd8;
                    end
                end else begin
                    n_st = E_IDLE;
                end
            end
            E_FLUSH: begin
                if (r_abc != '0) begin
                    push_req = 1'b1;
                    push_ch  = r_acc[63:56];
                    if (push_ok) begin
                        n_acc = r_acc << 8;
                        n_abc = (r_abc > 7'd8) ? r_abc - 7'd8 : '0;
                    end
                end else begin
                    n_col = '0;
                    n_acc = '0;
                    n_st  = E_IDLE;
                end
            end
            E_GRP: begin
                if (!r_fin && r_grp == '0) begin
                    n_ch  = lzwa_pkg::CH_Z;
                    n_rem = '0;
                    n_st  = E_CH;
                end else begin
                    div_start = 1'b1;
                    n_st      = E_DIV;
                end
            end
            E_DIV: begin
                if (div_done) begin
                    n_idx = '0;
                    n_st  = E_NEXT;
                end
            end
            E_NEXT: begin
                if (r_rem != '0) begin
                    n_ch  = digits[r_idx];
                    n_idx = r_idx + 3'd1;
                    n_rem = r_rem - 3'd1;
                    n_st  = E_CH;
                end else begin
                    n_st = r_fin ? E_TILDE : E_IDLE;
                end
            end
            E_CH: begin
                push_req = 1'b1;
                if (push_ok) begin
                    if (col_inc >= lw_eff) begin
                        n_col = '0;
                        n_st  = E_NL;
                    end else begin
                        n_col = col_inc;
                        n_st  = E_NEXT;
                    end
                end
            end
            E_NL: begin
                push_req = 1'b1;
                push_ch  = lzwa_pkg::CH_NL;
                if (push_ok) begin
                    n_st = E_NEXT;
                end
            end
            E_TILDE: begin
                push_req = 1'b1;
                push_ch  = lzwa_pkg::CH_TILDE;
                if (push_ok) begin
                    n_col = '0;
                    n_st  = E_GT;
                end
            end
            E_GT: begin
                push_req = 1'b1;
                push_ch  = lzwa_pkg::CH_GT;
                if (push_ok) begin
                    n_acc = '0;
                    n_abc = '0;
                    n_fin = 1'b0;
                    n_st  = E_IDLE;
                end
            end
            E_LAST: begin
                if (!r_pend_v || out_free) begin
                    n_st = E_IDLE;
                end
            end
            default: n_st = E_IDLE;
        endcase
    end

    // hold one character back so the final beat of an item carries last_of_run
    always_comb begin
        n_out_v    = r_out_v && i_out_stall;
        n_out_ch   = r_out_ch;
        n_out_last = r_out_last;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        if (push_ok) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_ch   = r_pend;
                n_out_last = 1'b0;
            end
            n_pend   = push_ch;
            n_pend_v = 1'b1;
        end
        if (r_st == E_LAST && r_pend_v && out_free) begin
            n_out_v    = 1'b1;
            n_out_ch   = r_pend;
            n_out_last = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= E_IDLE;
            r_acc    <= '0;
            r_abc    <= '0;
            r_col    <= '0;
            r_rem    <= '0;
            r_idx    <= '0;
            r_fin    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_acc    <= n_acc;
            r_abc    <= n_abc;
            r_col    <= n_col;
            r_rem    <= n_rem;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp      <= n_grp;
        r_ch       <= n_ch;
        r_pend     <= n_pend;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
    end

    assign o_ready       = (r_st == E_IDLE);
    assign o_out_valid   = r_out_v;
    assign o_out_char    = r_out_ch;
    assign o_last_of_run = r_out_last;

endmodule

>>> hdl/lzwa_checker.sv
// Port-level checks of the compressor core and their bind.
module lzwa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       i_end_of_stream,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_char,
    input logic       o_last_of_run,
    input logic       i_cfg_we,
    input logic       i_cfg_index,
    input logic [7:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_of_run))
        else $error("stalled output beat changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not quiet after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken before the first was worked");

endmodule

bind lzw_compressor_ascii85_out_core lzwa_checker u_lzwa_checker (.*);
